@@ sv/e2c_pkg.sv @@
// Package for the epoch seconds to calendar converter.
// Holds the control-word types, the microcode program, the divide constants
// and the month-start table. Depends on nothing else.
package e2c_pkg;

    localparam int EPOCH_START_YEAR    = 1970;
    localparam int EPOCH_START_WEEKDAY = 4;

    localparam logic [7:0] YEAR_BASE = 8'((EPOCH_START_YEAR - 1900) % 256);
    localparam logic [1:0] C4_INIT   = 2'(EPOCH_START_YEAR % 4);
    localparam logic [6:0] C100_INIT = 7'(EPOCH_START_YEAR % 100);
    localparam logic [8:0] C400_INIT = 9'(EPOCH_START_YEAR % 400);

    localparam int         STEP_W    = 4;
    localparam logic [3:0] STEP_LAST = 4'd10;

    typedef enum logic [2:0] {
        OP_MUL,
        OP_QUO,
        OP_YEAR,
        OP_MONTH,
        OP_DONE
    } op_t;

    typedef enum logic [1:0] {
        DIV_60,
        DIV_24,
        DIV_7
    } div_sel_t;

    typedef enum logic [2:0] {
        DST_NONE,
        DST_SEC,
        DST_MIN,
        DST_HOUR,
        DST_WDAY
    } dst_t;

    typedef struct packed {
        op_t               op;
        div_sel_t          sel;
        dst_t              dst;
        logic              wr_t;
        logic [STEP_W-1:0] target;
    } ctrl_t;

    // Microcode: one control word per step. Loop steps jump to themselves
    // while their condition holds; the last step returns to step zero.
    function automatic ctrl_t ctrl_word(input logic [STEP_W-1:0] step);
        ctrl_t c;
        c = '{op: OP_DONE, sel: DIV_60, dst: DST_NONE, wr_t: 1'b0, target: '0};
        case (step)
            4'd0:  c = '{op: OP_MUL,   sel: DIV_60, dst: DST_NONE, wr_t: 1'b0, target: 4'd0};
            4'd1:  c = '{op: OP_QUO,   sel: DIV_60, dst: DST_SEC,  wr_t: 1'b1, target: 4'd0};
            4'd2:  c = '{op: OP_MUL,   sel: DIV_60, dst: DST_NONE, wr_t: 1'b0, target: 4'd0};
            4'd3:  c = '{op: OP_QUO,   sel: DIV_60, dst: DST_MIN,  wr_t: 1'b1, target: 4'd0};
            4'd4:  c = '{op: OP_MUL,   sel: DIV_24, dst: DST_NONE, wr_t: 1'b0, target: 4'd0};
            4'd5:  c = '{op: OP_QUO,   sel: DIV_24, dst: DST_HOUR, wr_t: 1'b1, target: 4'd0};
            4'd6:  c = '{op: OP_MUL,   sel: DIV_7,  dst: DST_NONE, wr_t: 1'b0, target: 4'd0};
            4'd7:  c = '{op: OP_QUO,   sel: DIV_7,  dst: DST_WDAY, wr_t: 1'b0, target: 4'd0};
            4'd8:  c = '{op: OP_YEAR,  sel: DIV_60, dst: DST_NONE, wr_t: 1'b0, target: 4'd8};
            4'd9:  c = '{op: OP_MONTH, sel: DIV_60, dst: DST_NONE, wr_t: 1'b0, target: 4'd9};
            4'd10: c = '{op: OP_DONE,  sel: DIV_60, dst: DST_NONE, wr_t: 1'b0, target: 4'd0};
            default: c = '{op: OP_DONE, sel: DIV_60, dst: DST_NONE, wr_t: 1'b0, target: '0};
        endcase
        return c;
    endfunction

    // Reciprocal constants: q = ((x >> pre) * recip) >> shift, exact over
    // the range each divisor sees.
    function automatic logic [31:0] div_recip(input div_sel_t sel);
        logic [31:0] k;
        case (sel)
            DIV_60:  k = 32'h8888_8889;
            DIV_24:  k = 32'hAAAA_AAAB;
            DIV_7:   k = 32'd74899;
            default: k = 32'h8888_8889;
        endcase
        return k;
    endfunction

    function automatic logic [5:0] div_shift(input div_sel_t sel);
        logic [5:0] s;
        case (sel)
            DIV_60:  s = 6'd37;
            DIV_24:  s = 6'd33;
            DIV_7:   s = 6'd19;
            default: s = 6'd37;
        endcase
        return s;
    endfunction

    function automatic logic [1:0] div_pre(input div_sel_t sel);
        logic [1:0] p;
        case (sel)
            DIV_24:  p = 2'd3;
            default: p = 2'd0;
        endcase
        return p;
    endfunction

    function automatic logic [5:0] div_const(input div_sel_t sel);
        logic [5:0] d;
        case (sel)
            DIV_60:  d = 6'd60;
            DIV_24:  d = 6'd24;
            DIV_7:   d = 6'd7;
            default: d = 6'd60;
        endcase
        return d;
    endfunction

    // Weekday offset is folded into the dividend of the mod-7 step.
    function automatic logic [2:0] div_add(input div_sel_t sel);
        logic [2:0] a;
        case (sel)
            DIV_7:   a = 3'(EPOCH_START_WEEKDAY);
            default: a = 3'd0;
        endcase
        return a;
    endfunction

    function automatic logic [8:0] month_start(input logic [3:0] idx);
        logic [8:0] v;
        case (idx)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd59;
            4'd3:    v = 9'd90;
            4'd4:    v = 9'd120;
            4'd5:    v = 9'd151;
            4'd6:    v = 9'd181;
            4'd7:    v = 9'd212;
            4'd8:    v = 9'd243;
            4'd9:    v = 9'd273;
            4'd10:   v = 9'd304;
            4'd11:   v = 9'd334;
            4'd12:   v = 9'd365;
            default: v = 9'd365;
        endcase
        return v;
    endfunction

endpackage

@@ sv/epoch_seconds_to_calendar.sv @@
// Epoch seconds to calendar converter, top level.
// Microcoded sequencer over a shared reciprocal multiplier, year and month
// search loops. Depends on e2c_pkg.
//
// Channel   Signals                                   Direction  Handshake
// config    cfg_write, cfg_wdata                      in         write at edge with cfg_write
// command   start, epoch_seconds, mode                in         taken when start && !busy
// result    done, second .. month                     out        one-cycle strobe on done
//
// The year search walks one year per cycle over the years past the epoch start
// (up to 136); the month search then steps up to the month index M.
// busy stays high from the accept edge until done pulses; one item at a time.
// The receiver cannot stall: done is high for a single cycle.
// rst_n clears control state and the zone offset asynchronously.
module epoch_seconds_to_calendar
    import e2c_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic signed [16:0] cfg_wdata,
    input  logic               start,
    input  logic [31:0]        epoch_seconds,
    input  logic               mode,
    output logic               busy,
    output logic               done,
    output logic [5:0]         second,
    output logic [5:0]         minute,
    output logic [4:0]         hour,
    output logic [2:0]         weekday,
    output logic [7:0]         years_since_1900,
    output logic [8:0]         day_of_year,
    output logic [4:0]         day_of_month,
    output logic [3:0]         month
);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic signed [16:0] zone_reg;

    logic [31:0] t_reg;
    logic [63:0] prod_reg;
    logic [7:0]  yr_reg;
    logic [1:0]  c4_reg;
    logic [6:0]  c100_reg;
    logic [8:0]  c400_reg;
    logic [3:0]  m_reg;
    logic [5:0]  sec_reg;
    logic [5:0]  min_reg;
    logic [4:0]  hour_reg;
    logic [2:0]  wday_reg;
    logic [7:0]  year_out_reg;
    logic [8:0]  doy_reg;
    logic [4:0]  mday_reg;

    ctrl_t       ctrl;
    logic        accept;
    logic [31:0] x;
    logic [31:0] mul_in;
    logic [31:0] q;
    logic [5:0]  rem;
    logic        leap;
    logic [8:0]  year_len;
    logic        year_more;
    logic [8:0]  next_start;
    logic        month_more;
    logic [8:0]  cur_start;
    logic [4:0]  mday;

    assign accept = start && !busy_reg;

    always_comb
    begin
        ctrl       = ctrl_word(step_reg);
        x          = t_reg + 32'(div_add(ctrl.sel));
        mul_in     = x >> div_pre(ctrl.sel);
        q          = 32'(prod_reg >> div_shift(ctrl.sel));
        rem        = 6'(x - q * 32'(div_const(ctrl.sel)));
        leap       = (c4_reg == 2'd0) && ((c100_reg != 7'd0) || (c400_reg == 9'd0));
        year_len   = leap ? 9'd366 : 9'd365;
        year_more  = t_reg >= 32'(year_len);
        next_start = month_start(m_reg + 4'd1) + 9'(leap && (m_reg != 4'd0));
        month_more = (m_reg < 4'd11) && (32'(next_start) <= t_reg);
        cur_start  = month_start(m_reg) + 9'(leap && (m_reg > 4'd1));
        mday       = 5'(t_reg[8:0] - cur_start + 9'd1);
    end

    // Sequencer: step counter with conditional jumps from the control word.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        if (accept)
        begin
            busy_next = 1'b1;
            step_next = '0;
        end
        else if (busy_reg)
        begin
            case (ctrl.op)
                OP_YEAR:  step_next = year_more  ? ctrl.target : step_reg + 4'd1;
                OP_MONTH: step_next = month_more ? ctrl.target : step_reg + 4'd1;
                OP_DONE:
                begin
                    step_next = ctrl.target;
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
                default:  step_next = step_reg + 4'd1;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            zone_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
            if (cfg_write)
            begin
                zone_reg <= cfg_wdata;
            end
        end
    end

    // Datapath driven by the current control word.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            t_reg    <= epoch_seconds + (mode ? {{15{zone_reg[16]}}, zone_reg} : 32'd0);
            yr_reg   <= '0;
            c4_reg   <= C4_INIT;
            c100_reg <= C100_INIT;
            c400_reg <= C400_INIT;
            m_reg    <= '0;
        end
        else if (busy_reg)
        begin
            case (ctrl.op)
                OP_MUL:
                begin
                    prod_reg <= {32'd0, mul_in} * {32'd0, div_recip(ctrl.sel)};
                end
                OP_QUO:
                begin
                    if (ctrl.wr_t)
                    begin
                        t_reg <= q;
                    end
                    case (ctrl.dst)
                        DST_SEC:  sec_reg  <= rem;
                        DST_MIN:  min_reg  <= rem;
                        DST_HOUR: hour_reg <= rem[4:0];
                        DST_WDAY: wday_reg <= rem[2:0];
                        default:  ;
                    endcase
                end
                OP_YEAR:
                begin
                    if (year_more)
                    begin
                        t_reg    <= t_reg - 32'(year_len);
                        yr_reg   <= yr_reg + 8'd1;
                        c4_reg   <= c4_reg + 2'd1;
                        c100_reg <= (c100_reg == 7'd99)  ? 7'd0 : c100_reg + 7'd1;
                        c400_reg <= (c400_reg == 9'd399) ? 9'd0 : c400_reg + 9'd1;
                    end
                end
                OP_MONTH:
                begin
                    if (month_more)
                    begin
                        m_reg <= m_reg + 4'd1;
                    end
                end
                OP_DONE:
                begin
                    mday_reg     <= mday;
                    doy_reg      <= t_reg[8:0];
                    year_out_reg <= YEAR_BASE + yr_reg;
                end
                default: ;
            endcase
        end
    end

    assign busy             = busy_reg;
    assign done             = done_reg;
    assign second           = sec_reg;
    assign minute           = min_reg;
    assign hour             = hour_reg;
    assign weekday          = wday_reg;
    assign years_since_1900 = year_out_reg;
    assign day_of_year      = doy_reg;
    assign day_of_month     = mday_reg;
    assign month            = m_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && step_reg == '0))
        else $error("accepted transaction did not start the program");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (step_reg <= STEP_LAST))
        else $error("step counter out of program");

    a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy_reg && step_reg == STEP_LAST))
        else $error("result without the final step");

    a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (month <= 4'd11 && second <= 6'd59 && minute <= 6'd59))
        else $error("result field out of range");

endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for epoch_seconds_to_calendar: command transactions with a
// calendar predictor in a scoreboard class, checked against every done strobe.
// Depends on e2c_pkg and the epoch_seconds_to_calendar RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import e2c_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 3_000_000;
    localparam int unsigned DRAIN_CYCLES = 200;
    localparam int unsigned RANDOM_PHASES = 8;
    localparam int unsigned ITEMS_PER_PHASE = 250;
    localparam logic signed [16:0] ZONE_WEST = -17'sd50400;
    localparam logic signed [16:0] ZONE_EAST = 17'sd50400;
    localparam logic signed [16:0] ZONE_MOST_NEG = 17'h10000;
    localparam logic signed [16:0] ZONE_MOST_POS = 17'h0FFFF;
    localparam int unsigned SECS_PER_DAY = 86400;

    typedef struct packed {
        logic [5:0] sec;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [2:0] wday;
        logic [7:0] year;
        logic [8:0] yday;
        logic [4:0] mday;
        logic [3:0] mon;
    } cal_t;

    class calendar_scoreboard;
        cal_t expected_q[$];
        logic signed [16:0] zone;
        int errors;
        int unsigned month_first[13];

        function new();
            zone = '0;
            errors = 0;
            month_first = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365};
        endfunction

        static function bit gregorian_leap(input int unsigned y);
            return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
        endfunction

        function void set_zone(input logic signed [16:0] value);
            zone = value;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function cal_t to_calendar(input logic [31:0] secs, input logic local_mode);
            cal_t c;
            logic [31:0] t;
            logic [31:0] days;
            int unsigned yr;
            int unsigned len;
            int unsigned m;
            int unsigned extra;
            bit leap;
            t = secs;
            // sign-extend the zone and let the sum wrap at 32 bits
            if (local_mode)
                t = secs + {{15{zone[16]}}, zone};
            c.sec = 6'(t % 60);
            t = t / 60;
            c.minute = 6'(t % 60);
            t = t / 60;
            c.hour = 5'(t % 24);
            days = t / 24;
            c.wday = 3'((days + EPOCH_START_WEEKDAY) % 7);
            yr = 0;
            forever
            begin
                leap = gregorian_leap(EPOCH_START_YEAR + yr);
                len = leap ? 366 : 365;
                if (days < len)
                    break;
                days = days - len;
                yr++;
            end
            c.year = 8'(EPOCH_START_YEAR - 1900 + yr);
            c.yday = 9'(days);
            for (m = 0; m < 11; m++)
            begin
                extra = (leap && m > 0) ? 1 : 0;
                if (month_first[m + 1] + extra > days)
                    break;
            end
            extra = (leap && m > 1) ? 1 : 0;
            c.mday = 5'(days - (month_first[m] + extra) + 1);
            c.mon = 4'(m);
            return c;
        endfunction

        function void note_command(input logic [31:0] secs, input logic local_mode);
            expected_q.push_back(to_calendar(secs, local_mode));
        endfunction

        function void compare_field(input string name, input int unsigned want,
                                    input int unsigned got);
            if (want != got)
            begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(input cal_t got);
            cal_t want;
            if (expected_q.size() == 0)
            begin
                $error("result strobe with no transaction pending");
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("second", want.sec, got.sec);
            compare_field("minute", want.minute, got.minute);
            compare_field("hour", want.hour, got.hour);
            compare_field("weekday", want.wday, got.wday);
            compare_field("years_since_1900", want.year, got.year);
            compare_field("day_of_year", want.yday, got.yday);
            compare_field("day_of_month", want.mday, got.mday);
            compare_field("month", want.mon, got.mon);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic signed [16:0] cfg_wdata = '0;
    logic start = 1'b0;
    logic [31:0] epoch_seconds = '0;
    logic mode = 1'b0;
    logic busy;
    logic done;
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [2:0] weekday;
    logic [7:0] years_since_1900;
    logic [8:0] day_of_year;
    logic [4:0] day_of_month;
    logic [3:0] month;

    calendar_scoreboard sb = new();
    int unsigned cycles = 0;

    epoch_seconds_to_calendar uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_wdata        (cfg_wdata),
        .start            (start),
        .epoch_seconds    (epoch_seconds),
        .mode             (mode),
        .busy             (busy),
        .done             (done),
        .second           (second),
        .minute           (minute),
        .hour             (hour),
        .weekday          (weekday),
        .years_since_1900 (years_since_1900),
        .day_of_year      (day_of_year),
        .day_of_month     (day_of_month),
        .month            (month)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result('{sec: second, minute: minute, hour: hour, wday: weekday,
                              year: years_since_1900, yday: day_of_year,
                              mday: day_of_month, mon: month});
    end

    // Seconds at the start of a given day of a given year, for boundary targeting.
    function automatic longint secs_at(input int unsigned y, input int unsigned doy);
        longint days;
        int unsigned k;
        days = doy;
        for (k = EPOCH_START_YEAR; k < y; k++)
            days += calendar_scoreboard::gregorian_leap(k) ? 366 : 365;
        return days * SECS_PER_DAY;
    endfunction

    task automatic issue(input logic [31:0] secs, input logic local_mode);
        @(negedge clk);
        start <= 1'b1;
        epoch_seconds <= secs;
        mode <= local_mode;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_command(secs, local_mode);
    endtask

    task automatic idle_for(input int unsigned n);
        if (n > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (n - 1)
                @(negedge clk);
        end
    endtask

    // Drop start and hold off until every pending transaction has returned.
    task automatic wait_idle();
        @(negedge clk);
        start <= 1'b0;
        while (sb.pending() != 0 || busy)
            @(posedge clk);
        repeat (2)
            @(posedge clk);
    endtask

    task automatic load_zone(input logic signed [16:0] value);
        wait_idle();
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        sb.set_zone(value);
    endtask

    function automatic logic [31:0] pick_seconds();
        int unsigned kind;
        longint v;
        kind = $urandom_range(0, 9);
        if (kind <= 3)
            v = $urandom;
        else if (kind <= 5)
            // straddle a new year
            v = secs_at($urandom_range(1970, 2106), 0) - 2 * SECS_PER_DAY
                + $urandom_range(0, 4 * SECS_PER_DAY);
        else if (kind <= 7)
            // around the end of February
            v = secs_at($urandom_range(1970, 2105), $urandom_range(57, 61))
                + $urandom_range(0, SECS_PER_DAY - 1);
        else if (kind == 8)
            v = 64'hFFFF_FFFF - $urandom_range(0, 200000);
        else
            v = $urandom_range(0, 200000);
        return 32'(v);
    endfunction

    task automatic run_random(input int unsigned count);
        int unsigned burst;
        int unsigned i;
        burst = 0;
        for (i = 0; i < count; i++)
        begin
            if (burst == 0)
            begin
                burst = $urandom_range(1, 40);
                if ($urandom_range(0, 3) == 0)
                    idle_for($urandom_range(20, 180));
                else
                    idle_for($urandom_range(0, 6));
            end
            issue(pick_seconds(), 1'($urandom_range(0, 1)));
            burst--;
        end
    endtask

    initial
    begin
        int unsigned p;
        logic signed [16:0] z;
        repeat (8)
            @(negedge clk);
        rst_n <= 1'b1;

        // reset zone of zero, calendar corner cases
        issue(32'd0, 1'b0);
        issue(32'hFFFF_FFFF, 1'b0);
        issue(32'd0, 1'b1);
        issue(32'd86399, 1'b0);
        issue(32'(secs_at(1972, 365) + SECS_PER_DAY - 1), 1'b0);
        issue(32'(secs_at(2000, 59)), 1'b0);
        issue(32'(secs_at(2000, 60)), 1'b0);
        issue(32'(secs_at(2001, 0) - 1), 1'b0);
        issue(32'(secs_at(2100, 59) - 1), 1'b0);
        issue(32'(secs_at(2100, 59)), 1'b0);
        issue(32'(secs_at(2106, 0)), 1'b1);

        // local sums wrapping across zero in both directions
        load_zone(ZONE_WEST);
        issue(32'd0, 1'b1);
        issue(32'd50399, 1'b1);
        issue(32'd50400, 1'b1);
        issue(32'hFFFF_FFFF, 1'b1);

        load_zone(ZONE_EAST);
        issue(32'hFFFF_FFFF, 1'b1);
        issue(32'hFFFF_3B20, 1'b1);
        issue(32'd0, 1'b1);

        // patterns outside the nominal offset range
        load_zone(ZONE_MOST_NEG);
        issue(32'd0, 1'b1);
        issue(32'hFFFF_FFFF, 1'b1);
        issue(32'hFFFF_FFFF, 1'b0);

        load_zone(ZONE_MOST_POS);
        issue(32'hFFFF_FFFF, 1'b1);

        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p % 4)
                0: z = 17'($signed($urandom_range(0, 100800)) - 50400);
                1: z = 17'($urandom);
                2: z = $urandom_range(0, 1) ? ZONE_EAST : ZONE_WEST;
                default: z = '0;
            endcase
            load_zone(z);
            run_random(ITEMS_PER_PHASE);
        end

        wait_idle();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
